// ===== rtl/core/sem_pkg.sv =====
package sem_pkg;

   // Pixel and word layout: blue in the low byte, then green, then red.
   localparam int PIX_W      = 8;
   localparam int CHANNELS   = 3;
   localparam int WORD_W     = PIX_W * CHANNELS;
   localparam int CFG_W      = 11;
   localparam int WIN_TAPS   = 9;

   // Gradient and square root sizes.
   localparam int GRAD_W     = 11;
   localparam int RAD_W      = 24;
   localparam int ROOT_W     = 12;
   localparam int ROOT_STEPS = 12;
   localparam int PIX_MAX    = 255;

   typedef logic [PIX_W-1:0]         chan_type;
   typedef logic [WORD_W-1:0]        word_type;
   typedef logic signed [GRAD_W-1:0] grad_type;

   typedef enum logic [0:0] {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } reg_index_type;

   // Which sides of the 3x3 window fall outside the frame.
   typedef struct packed {
      logic top;
      logic bottom;
      logic left;
      logic right;
   } border_type;

endpackage

// ===== rtl/core/sem_ram.sv =====
module sem_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/sem_grad.sv =====
module sem_grad (
   input  sem_pkg::word_type   win [sem_pkg::WIN_TAPS],
   input  sem_pkg::border_type border,
   output sem_pkg::grad_type   gx [sem_pkg::CHANNELS],
   output sem_pkg::grad_type   gy [sem_pkg::CHANNELS]
);

   sem_pkg::grad_type tap [sem_pkg::CHANNELS][sem_pkg::WIN_TAPS];

   // Zero the taps that lie outside the frame, then apply both kernels.
   always_comb begin
      for (int ch = 0; ch < sem_pkg::CHANNELS; ch++) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               if ((r == 0 && border.top) || (r == 2 && border.bottom) ||
                   (c == 0 && border.left) || (c == 2 && border.right)) begin
                  tap[ch][r*3+c] = '0;
               end else begin
                  tap[ch][r*3+c] = sem_pkg::GRAD_W'(
                     {1'b0, win[r*3+c][ch*sem_pkg::PIX_W +: sem_pkg::PIX_W]});
               end
            end
         end
         gx[ch] = (tap[ch][2] + (tap[ch][5] <<< 1) + tap[ch][8]) -
                  (tap[ch][0] + (tap[ch][3] <<< 1) + tap[ch][6]);
         gy[ch] = (tap[ch][6] + (tap[ch][7] <<< 1) + tap[ch][8]) -
                  (tap[ch][0] + (tap[ch][1] <<< 1) + tap[ch][2]);
      end
   end

endmodule

// ===== rtl/core/sem_sqrt.sv =====
module sem_sqrt (
   input  logic              clock,
   input  logic              load,
   input  logic              step,
   input  sem_pkg::grad_type gx,
   input  sem_pkg::grad_type gy,
   output sem_pkg::chan_type mag
);

   localparam int REM_W = sem_pkg::ROOT_W + 1;
   localparam int CAT_W = REM_W + 2;
   localparam int SQ_W  = 2 * sem_pkg::GRAD_W;

   logic [sem_pkg::RAD_W-1:0]  rad_ff,  rad_in;
   logic [REM_W-1:0]           rem_ff,  rem_in;
   logic [sem_pkg::ROOT_W-1:0] root_ff, root_in;

   logic signed [SQ_W-1:0]     sq_x, sq_y;
   logic [sem_pkg::RAD_W-1:0]  sq_sum;
   logic [CAT_W-1:0]           rem_cat, trial;
   logic [sem_pkg::ROOT_W:0]   root_inc;
   logic [sem_pkg::ROOT_W-1:0] root_half;

   assign sq_x   = gx * gx;
   assign sq_y   = gy * gy;
   assign sq_sum = sem_pkg::RAD_W'($unsigned(sq_x)) + sem_pkg::RAD_W'($unsigned(sq_y));

   // Digit by digit root of 4s, two radicand bits per step.
   assign rem_cat = {rem_ff, rad_ff[sem_pkg::RAD_W-1 -: 2]};
   assign trial   = CAT_W'({root_ff, 2'b01});

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (load) begin
         rad_in  = {sq_sum[sem_pkg::RAD_W-3:0], 2'b00};
         rem_in  = '0;
         root_in = '0;
      end else if (step) begin
         rad_in = {rad_ff[sem_pkg::RAD_W-3:0], 2'b00};
         if (rem_cat >= trial) begin
            rem_in  = REM_W'(rem_cat - trial);
            root_in = {root_ff[sem_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = REM_W'(rem_cat);
            root_in = {root_ff[sem_pkg::ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   // floor(sqrt(4s)) = q gives the rounded root (q+1)/2, clamped to a byte.
   assign root_inc  = {1'b0, root_ff} + 1'b1;
   assign root_half = root_inc[sem_pkg::ROOT_W:1];
   assign mag = (32'(root_half) > sem_pkg::PIX_MAX) ? sem_pkg::chan_type'(sem_pkg::PIX_MAX)
                                                    : root_half[sem_pkg::PIX_W-1:0];

endmodule

// ===== rtl/core/sobel_edge_magnitude_rgb_core.sv =====
// Sobel edge magnitude per RGB channel over a raster pixel stream.
// A beat that yields a result goes through the read, gradient, load, root and done states to
// rsp_tvalid, and the next beat is taken once back in idle; each channel has its own 12-step root.
// A beat that yields no result only reads and writes back the line store; an ignored
// flush is taken without leaving idle. A result lags its pixel by frame_width+1 beats. Synchronous
// active-high reset clears the window, counters and output; line stores are not cleared.
module sobel_edge_magnitude_rgb_core #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [sem_pkg::WORD_W-1:0]   req_tdata,   // pixel_blue, pixel_green, pixel_red
   input  logic [0:0]                   req_tuser,   // flush
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [sem_pkg::WORD_W-1:0]   rsp_tdata,   // edge_blue, edge_green, edge_red
   output logic                         rsp_tlast,
   input  logic                         csr_we,
   input  logic [0:0]                   csr_addr,
   input  logic [sem_pkg::CFG_W-1:0]    csr_wdata
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int IROW_W = $clog2(MAX_HEIGHT + 2);
   localparam int OROW_W = $clog2(MAX_HEIGHT + 1);
   localparam int CNT_W  = $clog2(sem_pkg::ROOT_STEPS);
   localparam int LINE_W = 2 * sem_pkg::WORD_W;
   localparam int FW_RST = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
   localparam int FH_RST = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_READ = 6'b000010,
      ST_GRAD = 6'b000100,
      ST_LOAD = 6'b001000,
      ST_ROOT = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

   function automatic logic [sem_pkg::CFG_W-1:0] clamp_dim(
      input logic [sem_pkg::CFG_W-1:0] v,
      input int                        limit
   );
      logic [sem_pkg::CFG_W-1:0] d;
      d = (v == '0) ? sem_pkg::CFG_W'(1) : v;
      if (32'(d) > limit) begin
         d = sem_pkg::CFG_W'(limit);
      end
      return d;
   endfunction

   state_type                 state_ff, state_in;
   logic [sem_pkg::CFG_W-1:0] fw_ff, fw_in, fh_ff, fh_in;
   logic [COL_W-1:0]          in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [IROW_W-1:0]         in_row_ff, in_row_in;
   logic [OROW_W-1:0]         out_row_ff, out_row_in;
   sem_pkg::word_type         win_ff [sem_pkg::WIN_TAPS];
   sem_pkg::word_type         win_in [sem_pkg::WIN_TAPS];
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   sem_pkg::word_type         pix_ff, pix_in;
   sem_pkg::grad_type         gx_ff [sem_pkg::CHANNELS];
   sem_pkg::grad_type         gx_in [sem_pkg::CHANNELS];
   sem_pkg::grad_type         gy_ff [sem_pkg::CHANNELS];
   sem_pkg::grad_type         gy_in [sem_pkg::CHANNELS];
   logic                      last_ff, last_in;
   sem_pkg::word_type         rsp_data_ff, rsp_data_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic                      in_frame, primed, sqrt_load, sqrt_step;
   logic                      ram_rd_en, ram_wr_en;
   logic [LINE_W-1:0]         ram_rd_data;
   sem_pkg::word_type         line_up, line_mid;
   sem_pkg::border_type       border;
   sem_pkg::grad_type         gx_w [sem_pkg::CHANNELS];
   sem_pkg::grad_type         gy_w [sem_pkg::CHANNELS];
   sem_pkg::chan_type         mag [sem_pkg::CHANNELS];

   // Both line stores share one memory word: upper row low, middle row high.
   sem_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (in_col_ff),
      .wr_data ({pix_ff, line_mid}),
      .rd_en   (ram_rd_en),
      .rd_addr (in_col_ff),
      .rd_data (ram_rd_data)
   );

   assign line_up  = ram_rd_data[sem_pkg::WORD_W-1:0];
   assign line_mid = ram_rd_data[LINE_W-1:sem_pkg::WORD_W];

   assign in_frame = 32'(in_row_ff) < 32'(fh_ff);
   assign primed   = (32'(in_row_ff) >= 2) ||
                     (32'(in_row_ff) == 1 && 32'(in_col_ff) >= 1);

   // Frame border seen by the result being computed.
   assign border.top    = (out_row_ff == '0);
   assign border.bottom = (32'(out_row_ff) + 1 >= 32'(fh_ff));
   assign border.left   = (out_col_ff == '0);
   assign border.right  = (32'(out_col_ff) + 1 >= 32'(fw_ff));

   sem_grad u_grad (
      .win    (win_ff),
      .border (border),
      .gx     (gx_w),
      .gy     (gy_w)
   );

   for (genvar ch = 0; ch < sem_pkg::CHANNELS; ch++) begin : g_root
      sem_sqrt u_sqrt (
         .clock (clock),
         .load  (sqrt_load),
         .step  (sqrt_step),
         .gx    (gx_ff[ch]),
         .gy    (gy_ff[ch]),
         .mag   (mag[ch])
      );
   end

   assign req_tready = (state_ff == ST_IDLE);

   // Sequencer: read line stores, write back and shift, gradients, root, output.
   always_comb begin
      state_in     = state_ff;
      fw_in        = fw_ff;
      fh_in        = fh_ff;
      in_col_in    = in_col_ff;
      in_row_in    = in_row_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      win_in       = win_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      pix_in       = pix_ff;
      gx_in        = gx_ff;
      gy_in        = gy_ff;
      last_in      = last_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      ram_rd_en    = 1'b0;
      ram_wr_en    = 1'b0;
      sqrt_load    = 1'b0;
      sqrt_step    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            // A flush inside the frame is taken and dropped.
            if (req_tvalid && !(req_tuser[0] && in_frame)) begin
               ram_rd_en = 1'b1;
               pix_in    = in_frame ? req_tdata : '0;
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            ram_wr_en = 1'b1;
            for (int r = 0; r < 3; r++) begin
               win_in[r*3]   = win_ff[r*3+1];
               win_in[r*3+1] = win_ff[r*3+2];
            end
            win_in[2] = line_up;
            win_in[5] = line_mid;
            win_in[8] = pix_ff;
            if (32'(in_row_ff) > 32'(fh_ff)) begin
               in_row_in = '0;
               in_col_in = '0;
            end else if (32'(in_col_ff) + 1 >= 32'(fw_ff)) begin
               in_col_in = '0;
               in_row_in = in_row_ff + 1'b1;
            end else begin
               in_col_in = in_col_ff + 1'b1;
            end
            state_in = primed ? ST_GRAD : ST_IDLE;
         end
         ST_GRAD: begin
            gx_in   = gx_w;
            gy_in   = gy_w;
            last_in = border.bottom && border.right;
            if (border.right) begin
               out_col_in = '0;
               out_row_in = border.bottom ? '0 : out_row_ff + 1'b1;
            end else begin
               out_col_in = out_col_ff + 1'b1;
            end
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            sqrt_load = 1'b1;
            cnt_in    = '0;
            state_in  = ST_ROOT;
         end
         ST_ROOT: begin
            sqrt_step = 1'b1;
            cnt_in    = cnt_ff + 1'b1;
            if (32'(cnt_ff) == sem_pkg::ROOT_STEPS - 1) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {mag[2], mag[1], mag[0]};
               rsp_last_in  = last_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A register write restarts the frame and drops pending results.
      if (csr_we) begin
         case (sem_pkg::reg_index_type'(csr_addr))
            sem_pkg::REG_FRAME_WIDTH:  fw_in = clamp_dim(csr_wdata, MAX_WIDTH);
            sem_pkg::REG_FRAME_HEIGHT: fh_in = clamp_dim(csr_wdata, MAX_HEIGHT);
            default: begin
            end
         endcase
         state_in     = ST_IDLE;
         in_col_in    = '0;
         in_row_in    = '0;
         out_col_in   = '0;
         out_row_in   = '0;
         rsp_valid_in = 1'b0;
         for (int k = 0; k < sem_pkg::WIN_TAPS; k++) begin
            win_in[k] = '0;
         end
      end
   end

   // Control state and window.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fw_ff        <= sem_pkg::CFG_W'(FW_RST);
         fh_ff        <= sem_pkg::CFG_W'(FH_RST);
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < sem_pkg::WIN_TAPS; k++) begin
            win_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         fw_ff        <= fw_in;
         fh_ff        <= fh_in;
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         win_ff       <= win_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pix_ff      <= pix_in;
      gx_ff       <= gx_in;
      gy_ff       <= gy_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== rtl/core/sem_checker.sv =====
module sem_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic [0:0]                 req_tuser,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [sem_pkg::WORD_W-1:0] rsp_tdata,
   input logic                       rsp_tlast,
   input logic                       csr_we
);

   // A stalled result beat stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready && !csr_we |=> rsp_tvalid)
      else $error("result beat withdrawn while stalled");

   // A stalled result beat keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready && !csr_we |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result payload changed while stalled");

   // Reset leaves the block empty and ready.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not empty after reset");

   // A register write drops any pending result.
   a_cfg_drop: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !rsp_tvalid)
      else $error("result pending after register write");

   // A pixel beat without a register write occupies the line store access, so input is not ready in the cycle after it.
   a_pixel_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser[0] && !csr_we |=> !req_tready)
      else $error("input ready right after a pixel beat");

endmodule

bind sobel_edge_magnitude_rgb_core sem_checker u_sem_checker (.*);
